FILE: rtl/core/mrc_pkg.sv
`default_nettype none

package mrc_pkg;

    // Field widths of the streams and of the configuration port.
    localparam int CMD_W       = 3;
    localparam int AXIS_W      = 2;
    localparam int COORD_W     = 16;
    localparam int POS_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int NUM_AXES_W  = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int NUM_SIZES   = 4;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;

    localparam int MAX_AXES_DEF = 4;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_REWIND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INC     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEC     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BOUNDS   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_AXIS  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_AXES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS3 = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/core/mrc_mul.sv
`default_nettype none

module mrc_mul
    import mrc_pkg::*;
#(
    parameter int A_W = POS_W + 1,
    parameter int B_W = COORD_W
) (
    input  wire logic               aclk,
    input  wire logic               start,
    input  wire logic [A_W-1:0]     mul_a,
    input  wire logic [B_W-1:0]     mul_b,
    output logic      [A_W+B_W-1:0] product
);

    localparam int P_W = A_W + B_W;

    logic [P_W-1:0] product_reg;

    // The product is registered so that nothing else follows the multiplier in the same cycle.
    always_ff @(posedge aclk) begin
        if (start) begin
            product_reg <= P_W'(mul_a) * P_W'(mul_b);
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

FILE: rtl/core/mrc_regs.sv
`default_nettype none

module mrc_regs
    import mrc_pkg::*;
#(
    parameter int MAX_AXES = MAX_AXES_DEF,
    parameter int IDX_W    = $clog2(MAX_AXES + 1)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [IDX_W-1:0]      sel_idx,
    output logic      [IDX_W-1:0]      used_axes,
    output logic      [COORD_W-1:0]    size_sel
);

    localparam int CMP_W = (IDX_W > NUM_AXES_W) ? IDX_W : NUM_AXES_W;

    logic [NUM_AXES_W-1:0] num_axes_reg;
    logic [COORD_W-1:0]    size_reg [NUM_SIZES];
    logic [CMP_W-1:0]      num_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_axes_reg <= '0;
            for (int i = 0; i < NUM_SIZES; i++) begin
                size_reg[i] <= COORD_W'(1);
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_NUM_AXES:   num_axes_reg <= cfg_wdata[NUM_AXES_W-1:0];
                REG_SIZE_AXIS0: size_reg[0]  <= cfg_wdata[COORD_W-1:0];
                REG_SIZE_AXIS1: size_reg[1]  <= cfg_wdata[COORD_W-1:0];
                REG_SIZE_AXIS2: size_reg[2]  <= cfg_wdata[COORD_W-1:0];
                REG_SIZE_AXIS3: size_reg[3]  <= cfg_wdata[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // More axes than the block holds are clamped to the largest count.
    always_comb begin
        num_ext = CMP_W'(num_axes_reg);
        if (num_ext > CMP_W'(MAX_AXES)) begin
            used_axes = IDX_W'(MAX_AXES);
        end else begin
            used_axes = IDX_W'(num_ext);
        end
    end

    // A size of zero counts as one, as does every axis without a size register.
    always_comb begin
        size_sel = COORD_W'(1);
        for (int i = 0; i < NUM_SIZES; i++) begin
            if (int'(sel_idx) == i && size_reg[i] != '0) begin
                size_sel = size_reg[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mixed_radix_index_counter.sv
`default_nettype none

// Channel      | Direction | Ports                      | Contents of tdata, lowest bit up
// command in   | in        | s_tvalid s_tready s_tdata  | command, axis, value
// result out   | out       | m_tvalid m_tready m_tdata  | position, coordinate, end_passed, status
// config write | in        | cfg_wr_en cfg_index cfg_wdata | register index and value
//
// From one transfer in to the next: a rewind, query, unknown command, advance at the last
// position, command on an axis not in use or any command while the sizes overflow passes
// done; an out-of-bounds set, increment or decrement passes check and done; an advance
// passes a carry per axis it reaches, then done; a successful set, increment or decrement
// passes check, a multiply and add per axis in use to rebuild the position, and done. Reset
// and every mapped register write rebuild the strides by clear and at most a multiply and
// accumulate per axis in use, taking no command. A result waiting on m_tready does not block
// the next transfer in; a finished command waits only until the result register is free.

module mixed_radix_index_counter
    import mrc_pkg::*;
#(
    parameter int MAX_AXES = MAX_AXES_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // command[2:0], axis[4:3], value[20:5]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata,   // position[31:0], coordinate[47:32],
                                                   // end_passed[48], status[50:49]
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_AXES + 1);
    localparam int A_W   = POS_W + 1;
    localparam int P_W   = A_W + COORD_W;
    localparam int PAD_W = OUT_TDATA_W - POS_W - COORD_W - 1 - STATUS_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_INIT_STEP,
        ST_INIT_MUL,
        ST_INIT_ACC,
        ST_IDLE,
        ST_ADV_STEP,
        ST_ADV_CARRY,
        ST_CHECK,
        ST_RC_STEP,
        ST_RC_MUL,
        ST_RC_ADD,
        ST_DONE
    } state_t;

    state_t                state_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      axis_reg;
    logic [CMD_W-1:0]      cmd_reg;
    logic [COORD_W-1:0]    value_reg;
    logic                  in_use_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      total_m1_reg;
    logic [POS_W-1:0]      sum_reg;
    logic [A_W-1:0]        acc_reg;
    logic                  ovf_reg;
    logic                  end_reg;
    logic [COORD_W-1:0]    coord_reg [MAX_AXES];
    logic [POS_W-1:0]      stride_reg [MAX_AXES];

    logic                  m_tvalid_reg;
    logic [POS_W-1:0]      m_pos_reg;
    logic [COORD_W-1:0]    m_coord_reg;
    logic                  m_end_reg;
    logic [STATUS_W-1:0]   m_status_reg;

    logic [CMD_W-1:0]      in_cmd;
    logic [AXIS_W-1:0]     in_axis;
    logic [COORD_W-1:0]    in_value;
    logic                  in_use;
    logic [STATUS_W-1:0]   in_status;
    logic                  adv_go;
    logic                  chk_go;
    logic                  cfg_hit;
    logic                  m_load;

    logic [IDX_W-1:0]      used_axes;
    logic [COORD_W-1:0]    size_sel;
    logic [COORD_W-1:0]    coord_sel;
    logic [POS_W-1:0]      stride_sel;
    logic [COORD_W:0]      coord_inc;
    logic [COORD_W:0]      size_ext;
    logic                  chk_bad;
    logic [COORD_W-1:0]    chk_new;

    logic                  mul_start;
    logic [A_W-1:0]        mul_a;
    logic [COORD_W-1:0]    mul_b;
    logic [P_W-1:0]        product;
    logic                  prod_ovf;

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_axis  = s_tdata[CMD_W+AXIS_W-1:CMD_W];
    assign in_value = s_tdata[CMD_W+AXIS_W+COORD_W-1:CMD_W+AXIS_W];
    assign in_use   = int'(in_axis) < int'(used_axes);

    // Only the set, step and query commands check their axis.
    always_comb begin
        if (ovf_reg) begin
            in_status = STAT_OVERFLOW;
        end else if (!in_use && (in_cmd inside {CMD_SET, CMD_INC, CMD_DEC, CMD_QUERY})) begin
            in_status = STAT_NO_AXIS;
        end else begin
            in_status = STAT_OK;
        end
    end

    assign adv_go  = !ovf_reg && (in_cmd == CMD_ADVANCE) && (pos_reg < total_m1_reg);
    assign chk_go  = !ovf_reg && in_use && (in_cmd inside {CMD_SET, CMD_INC, CMD_DEC});
    assign cfg_hit = cfg_wr_en && (cfg_index inside {REG_NUM_AXES, REG_SIZE_AXIS0,
                                                     REG_SIZE_AXIS1, REG_SIZE_AXIS2,
                                                     REG_SIZE_AXIS3});
    assign m_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    mrc_regs #(
        .MAX_AXES (MAX_AXES),
        .IDX_W    (IDX_W)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sel_idx   (idx_reg),
        .used_axes (used_axes),
        .size_sel  (size_sel)
    );

    mrc_mul #(
        .A_W (A_W),
        .B_W (COORD_W)
    ) u_mul (
        .aclk    (aclk),
        .start   (mul_start),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (product)
    );

    // Every coordinate and stride read goes through the one index register.
    always_comb begin
        coord_sel  = '0;
        stride_sel = '0;
        for (int i = 0; i < MAX_AXES; i++) begin
            if (int'(idx_reg) == i) begin
                coord_sel  = coord_reg[i];
                stride_sel = stride_reg[i];
            end
        end
    end

    assign coord_inc = {1'b0, coord_sel} + (COORD_W+1)'(1);
    assign size_ext  = {1'b0, size_sel};

    always_comb begin
        chk_bad = 1'b0;
        chk_new = coord_sel;
        case (cmd_reg)
            CMD_SET: begin
                chk_bad = value_reg >= size_sel;
                chk_new = value_reg;
            end
            CMD_INC: begin
                chk_bad = coord_inc >= size_ext;
                chk_new = coord_inc[COORD_W-1:0];
            end
            CMD_DEC: begin
                chk_bad = coord_sel == '0;
                chk_new = coord_sel - COORD_W'(1);
            end
            default: begin
                chk_bad = 1'b0;
                chk_new = coord_sel;
            end
        endcase
    end

    // The shared multiplier builds the total size while strides are set up, and
    // coordinate times stride while the position is rebuilt.
    always_comb begin
        mul_start = (state_reg == ST_INIT_MUL) || (state_reg == ST_RC_MUL);
        if (state_reg == ST_INIT_MUL) begin
            mul_a = acc_reg;
            mul_b = size_sel;
        end else begin
            mul_a = {1'b0, stride_sel};
            mul_b = coord_sel;
        end
    end

    // The running product overflows once it is above two to the power of the position width.
    assign prod_ovf = (|product[P_W-1:POS_W+1]) || (product[POS_W] && (|product[POS_W-1:0]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_load) begin
                m_tvalid_reg <= 1'b1;
                m_pos_reg    <= pos_reg;
                m_coord_reg  <= in_use_reg ? coord_sel : '0;
                m_end_reg    <= end_reg;
                m_status_reg <= status_reg;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // A write to a mapped register starts the counter afresh.
            if (cfg_hit) begin
                state_reg <= ST_CLEAR;
            end else begin
                case (state_reg)
                    ST_CLEAR: begin
                        pos_reg <= '0;
                        end_reg <= 1'b0;
                        ovf_reg <= 1'b0;
                        acc_reg <= A_W'(1);
                        idx_reg <= used_axes;
                        for (int i = 0; i < MAX_AXES; i++) begin
                            coord_reg[i] <= '0;
                        end
                        state_reg <= ST_INIT_STEP;
                    end
                    ST_INIT_STEP: begin
                        if (idx_reg == '0) begin
                            total_m1_reg <= POS_W'(acc_reg - A_W'(1));
                            state_reg    <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg - IDX_W'(1);
                            state_reg <= ST_INIT_MUL;
                        end
                    end
                    ST_INIT_MUL: begin
                        for (int i = 0; i < MAX_AXES; i++) begin
                            if (int'(idx_reg) == i) begin
                                stride_reg[i] <= acc_reg[POS_W-1:0];
                            end
                        end
                        state_reg <= ST_INIT_ACC;
                    end
                    ST_INIT_ACC: begin
                        if (prod_ovf) begin
                            ovf_reg   <= 1'b1;
                            state_reg <= ST_IDLE;
                        end else begin
                            acc_reg   <= product[A_W-1:0];
                            state_reg <= ST_INIT_STEP;
                        end
                    end
                    ST_IDLE: begin
                        if (s_tvalid) begin
                            cmd_reg    <= in_cmd;
                            value_reg  <= in_value;
                            in_use_reg <= in_use;
                            axis_reg   <= IDX_W'(in_axis);
                            status_reg <= in_status;
                            if (adv_go) begin
                                pos_reg   <= pos_reg + POS_W'(1);
                                idx_reg   <= used_axes;
                                state_reg <= ST_ADV_STEP;
                            end else begin
                                idx_reg   <= IDX_W'(in_axis);
                                state_reg <= chk_go ? ST_CHECK : ST_DONE;
                                if (!ovf_reg && (in_cmd == CMD_REWIND)) begin
                                    pos_reg <= '0;
                                    end_reg <= 1'b0;
                                    for (int i = 0; i < MAX_AXES; i++) begin
                                        coord_reg[i] <= '0;
                                    end
                                end else if (!ovf_reg && (in_cmd == CMD_ADVANCE)) begin
                                    end_reg <= 1'b1;
                                end
                            end
                        end
                    end
                    ST_ADV_STEP: begin
                        if (idx_reg == '0) begin
                            idx_reg   <= axis_reg;
                            state_reg <= ST_DONE;
                        end else begin
                            idx_reg   <= idx_reg - IDX_W'(1);
                            state_reg <= ST_ADV_CARRY;
                        end
                    end
                    ST_ADV_CARRY: begin
                        // An axis that wraps carries into the next slower one.
                        for (int i = 0; i < MAX_AXES; i++) begin
                            if (int'(idx_reg) == i) begin
                                coord_reg[i] <= (coord_inc < size_ext) ?
                                                coord_inc[COORD_W-1:0] : '0;
                            end
                        end
                        if (coord_inc < size_ext) begin
                            idx_reg   <= axis_reg;
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_ADV_STEP;
                        end
                    end
                    ST_CHECK: begin
                        if (chk_bad) begin
                            status_reg <= STAT_BOUNDS;
                            state_reg  <= ST_DONE;
                        end else begin
                            for (int i = 0; i < MAX_AXES; i++) begin
                                if (int'(idx_reg) == i) begin
                                    coord_reg[i] <= chk_new;
                                end
                            end
                            end_reg   <= 1'b0;
                            sum_reg   <= '0;
                            idx_reg   <= used_axes;
                            state_reg <= ST_RC_STEP;
                        end
                    end
                    ST_RC_STEP: begin
                        if (idx_reg == '0) begin
                            pos_reg   <= sum_reg;
                            idx_reg   <= axis_reg;
                            state_reg <= ST_DONE;
                        end else begin
                            idx_reg   <= idx_reg - IDX_W'(1);
                            state_reg <= ST_RC_MUL;
                        end
                    end
                    ST_RC_MUL: begin
                        state_reg <= ST_RC_ADD;
                    end
                    ST_RC_ADD: begin
                        sum_reg   <= sum_reg + product[POS_W-1:0];
                        state_reg <= ST_RC_STEP;
                    end
                    ST_DONE: begin
                        if (m_load) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    default: begin
                        state_reg <= ST_CLEAR;
                    end
                endcase
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {PAD_W'(0), m_status_reg, m_end_reg, m_coord_reg, m_pos_reg};

`ifndef SYNTH
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready in the cycle after a transfer");

    a_position_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) && !ovf_reg |-> pos_reg <= total_m1_reg)
        else $error("position beyond the last point of the array");

    a_no_axis_coordinate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[OUT_TDATA_W-PAD_W-1:OUT_TDATA_W-PAD_W-STATUS_W] == STAT_NO_AXIS)
        |-> m_tdata[POS_W+COORD_W-1:POS_W] == '0)
        else $error("coordinate reported for an axis not in use");
`endif

endmodule

`default_nettype wire
